// ----- rtl/core/bffa_pkg.sv -----
package bffa_pkg;

	localparam int MAP_BYTES_DEF = 4096;
	localparam int MAX_RUN_DEF   = 12;

	localparam int IDX_W     = 16;
	localparam int COUNT_MAX = 15;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_ALLOC = 2'd2;

	localparam logic [2:0] RES_GRANTED   = 3'd0;
	localparam logic [2:0] RES_READ      = 3'd1;
	localparam logic [2:0] RES_NO_SPACE  = 3'd2;
	localparam logic [2:0] RES_TOO_LARGE = 3'd3;
	localparam logic [2:0] RES_EMPTY     = 3'd4;

	localparam logic CFG_REGION_BLOCKS = 1'b0;
	localparam logic CFG_REGION_OFFSET = 1'b1;

	localparam logic [15:0] REGION_BLOCKS_RST = 16'd32768;

	typedef struct packed {
		logic [1:0]  mode;
		logic [11:0] byte_index;
		logic [7:0]  byte_value;
		logic [3:0]  request_count;
	} req_t;

	typedef struct packed {
		logic [31:0] block_number;
		logic [7:0]  read_byte;
		logic [2:0]  status;
		logic        last;
	} res_t;

	typedef struct packed {
		logic clear_en;
		logic load_en;
		logic read_issue;
		logic read_emit;
		logic imm_emit;
		logic scan_start;
		logic scan_step;
		logic nospace_emit;
		logic mark_rd;
		logic mark_wr;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic scan_hit;
		logic scan_full;
		logic scan_more;
		logic mark_last;
	} sts_t;

endpackage

// ----- rtl/core/bitmap_first_fit_block_allocator.sv -----
// Bitmap first-fit block allocator.
// Request channel: a request is taken on a rising edge with start high and busy
// low; req carries mode, byte_index, byte_value and request_count.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Index 0 is region_blocks, index 1 is region_offset.
// Result channel: result_valid strobes for one cycle per result; it cannot be held off.
// Load (mode 0) writes the byte on the accept edge, gives no result, busy stays low.
// Read (mode 1) keeps busy high for one cycle; its result is registered in the read
// data register, then in the result register. Empty and too-large allocate requests
// answer the cycle after accept without busy. Allocate scans the bitmap from byte 0
// with one byte-wide read port, stepping past bytes that hold no usable free bit and
// taking free bits one at a time, then marks each grant by a read-modify-write of its
// bitmap byte (a read state, then a write state that sends the grant's result).
// A failing scan visits up to max(1, ceil(min(region_blocks, 8*MAP_BYTES)/8)) bytes.
// After reset the block clears the bitmap, one byte a cycle, over all MAP_BYTES bytes
// with busy high; configuration writes are taken throughout.
module bitmap_first_fit_block_allocator import bffa_pkg::*; #(
	parameter int MAP_BYTES = MAP_BYTES_DEF,
	parameter int MAX_RUN   = MAX_RUN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output logic        result_valid,
	output res_t        result
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	bffa_ctrl #(
		.MAX_RUN(MAX_RUN)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	bffa_dp #(
		.MAP_BYTES(MAP_BYTES),
		.MAX_RUN  (MAX_RUN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.cmd         (cmd),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sts         (sts),
		.result      (result),
		.result_valid(result_valid)
	);

endmodule

// ----- rtl/core/bffa_ctrl.sv -----
module bffa_ctrl import bffa_pkg::*; #(
	parameter int MAX_RUN = MAX_RUN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	typedef enum logic [5:0] {
		S_CLEAR   = 6'b000001,
		S_IDLE    = 6'b000010,
		S_READ    = 6'b000100,
		S_SCAN    = 6'b001000,
		S_MARK_RD = 6'b010000,
		S_MARK_WR = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					case (req.mode)
						MODE_LOAD: begin
							cmd.load_en = 1'b1;
						end
						MODE_READ: begin
							cmd.read_issue = 1'b1;
							state_nx       = S_READ;
						end
						MODE_ALLOC: begin
							if (req.request_count == 4'd0 ||
							    32'(req.request_count) > 32'(MAX_RUN)) begin
								cmd.imm_emit = 1'b1;
							end else begin
								cmd.scan_start = 1'b1;
								state_nx       = S_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				cmd.read_emit = 1'b1;
				state_nx      = S_IDLE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_full) begin
					state_nx = S_MARK_RD;
				end else if (!sts.scan_hit && !sts.scan_more) begin
					cmd.nospace_emit = 1'b1;
					state_nx         = S_IDLE;
				end
			end
			S_MARK_RD: begin
				cmd.mark_rd = 1'b1;
				state_nx    = S_MARK_WR;
			end
			S_MARK_WR: begin
				cmd.mark_wr = 1'b1;
				state_nx    = sts.mark_last ? S_IDLE : S_MARK_RD;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ----- rtl/core/bffa_dp.sv -----
module bffa_dp import bffa_pkg::*; #(
	parameter int MAP_BYTES = MAP_BYTES_DEF,
	parameter int MAX_RUN   = MAX_RUN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  req_t        req,
	input  cmd_t        cmd,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output sts_t        sts,
	output res_t        result,
	output logic        result_valid
);

	localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int MAP_BITS  = MAP_BYTES * 8;
	localparam int RUN_DEPTH = (MAX_RUN < COUNT_MAX) ? MAX_RUN : COUNT_MAX;
	localparam int LW        = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
	localparam int FW        = $clog2(RUN_DEPTH + 1);

	logic [7:0]       map_mem [MAP_BYTES];
	logic [7:0]       map_rdata_q;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [7:0]       mem_wdata;

	logic [15:0]      region_blocks_q;
	logic [31:0]      region_offset_q;

	logic [AW-1:0]    clr_q;
	logic [13:0]      byte_q;
	logic [7:0]       taken_q;
	logic [FW-1:0]    found_q;
	logic [FW-1:0]    mark_k_q;
	logic [3:0]       want_q;
	logic             read_oob_q;
	logic [IDX_W-1:0] found_list_q [RUN_DEPTH];

	res_t             result_q;
	logic             result_valid_q;

	logic [31:0]      idx_wide;
	logic             idx_in_range;
	logic [15:0]      limit;
	logic [13:0]      lim_byte;
	logic [2:0]       lim_rem;
	logic [13:0]      next_byte;
	logic [31:0]      next_wide;
	logic [7:0]       vmask;
	logic [7:0]       free_bits;
	logic [2:0]       hit_pos;
	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] mark_entry;
	logic [31:0]      mark_wide;
	logic [AW-1:0]    mark_addr;
	logic [7:0]       mark_bit;

	assign idx_wide     = 32'(req.byte_index);
	assign idx_in_range = idx_wide < 32'(MAP_BYTES);

	assign limit     = (32'(region_blocks_q) < 32'(MAP_BITS)) ? region_blocks_q
	                                                         : 16'(MAP_BITS);
	assign lim_byte  = {1'b0, limit[15:3]};
	assign lim_rem   = limit[2:0];
	assign next_byte = byte_q + 14'd1;
	assign next_wide = 32'(next_byte);

	always_comb begin
		if (byte_q < lim_byte) begin
			vmask = 8'hFF;
		end else if (byte_q == lim_byte) begin
			vmask = (8'd1 << lim_rem) - 8'd1;
		end else begin
			vmask = 8'h00;
		end
	end

	assign free_bits = ~map_rdata_q & ~taken_q & vmask;

	always_comb begin
		hit_pos = 3'd0;
		for (int j = 7; j >= 0; j--) begin
			if (free_bits[j]) begin
				hit_pos = 3'(j);
			end
		end
	end

	assign hit_idx = {byte_q[12:0], hit_pos};

	assign sts.clear_last = (clr_q == AW'(MAP_BYTES - 1));
	assign sts.scan_hit   = |free_bits;
	assign sts.scan_full  = (|free_bits) && (32'(found_q) + 32'd1 == 32'(want_q));
	assign sts.scan_more  = (next_byte < lim_byte) || (next_byte == lim_byte && lim_rem != 3'd0);
	assign sts.mark_last  = (32'(mark_k_q) + 32'd1 == 32'(want_q));

	assign mark_entry = found_list_q[mark_k_q[LW-1:0]];
	assign mark_wide  = 32'(mark_entry[IDX_W-1:3]);
	assign mark_addr  = mark_wide[AW-1:0];
	assign mark_bit   = 8'd1 << mark_entry[2:0];

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		if (cmd.read_issue) begin
			mem_re    = 1'b1;
			mem_raddr = idx_wide[AW-1:0];
		end else if (cmd.scan_start) begin
			mem_re    = 1'b1;
		end else if (cmd.scan_step && !sts.scan_hit && sts.scan_more) begin
			mem_re    = 1'b1;
			mem_raddr = next_wide[AW-1:0];
		end else if (cmd.mark_rd) begin
			mem_re    = 1'b1;
			mem_raddr = mark_addr;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = 8'd0;
		if (cmd.clear_en) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
		end else if (cmd.load_en && idx_in_range) begin
			mem_we    = 1'b1;
			mem_waddr = idx_wide[AW-1:0];
			mem_wdata = req.byte_value;
		end else if (cmd.mark_wr) begin
			mem_we    = 1'b1;
			mem_waddr = mark_addr;
			mem_wdata = map_rdata_q | mark_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			map_rdata_q <= map_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_blocks_q <= REGION_BLOCKS_RST;
			region_offset_q <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REGION_BLOCKS: region_blocks_q <= cfg_data[15:0];
				CFG_REGION_OFFSET: region_offset_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			byte_q   <= '0;
			taken_q  <= '0;
			found_q  <= '0;
			mark_k_q <= '0;
			want_q   <= '0;
		end else begin
			if (cmd.clear_en) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.scan_start) begin
				byte_q   <= '0;
				taken_q  <= '0;
				found_q  <= '0;
				mark_k_q <= '0;
				want_q   <= req.request_count;
			end else if (cmd.scan_step) begin
				if (sts.scan_hit) begin
					taken_q <= taken_q | (8'd1 << hit_pos);
					found_q <= found_q + FW'(1);
				end else if (sts.scan_more) begin
					byte_q  <= next_byte;
					taken_q <= '0;
				end
			end
			if (cmd.mark_wr) begin
				mark_k_q <= mark_k_q + FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && sts.scan_hit) begin
			found_list_q[found_q[LW-1:0]] <= hit_idx;
		end
		if (cmd.read_issue) begin
			read_oob_q <= !idx_in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.read_emit || cmd.imm_emit || cmd.nospace_emit ||
			                  cmd.mark_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read_emit) begin
			result_q.block_number <= 32'd0;
			result_q.read_byte    <= read_oob_q ? 8'd0 : map_rdata_q;
			result_q.status       <= RES_READ;
			result_q.last         <= 1'b1;
		end else if (cmd.imm_emit) begin
			result_q.block_number <= 32'd0;
			result_q.read_byte    <= 8'd0;
			result_q.status       <= (req.request_count == 4'd0) ? RES_EMPTY : RES_TOO_LARGE;
			result_q.last         <= 1'b1;
		end else if (cmd.nospace_emit) begin
			result_q.block_number <= 32'd0;
			result_q.read_byte    <= 8'd0;
			result_q.status       <= RES_NO_SPACE;
			result_q.last         <= 1'b1;
		end else if (cmd.mark_wr) begin
			result_q.block_number <= region_offset_q + 32'(mark_entry);
			result_q.read_byte    <= 8'd0;
			result_q.status       <= RES_GRANTED;
			result_q.last         <= sts.mark_last;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

// ----- rtl/core/bffa_checker.sv -----
module bffa_checker import bffa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic result_valid,
	input res_t result
);

	a_mid_is_grant: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> result.status == RES_GRANTED)
		else $error("non-final result is not a grant");

	a_zero_block: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != RES_GRANTED |-> result.block_number == 32'd0)
		else $error("block number set on a non-grant result");

	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != RES_READ |-> result.read_byte == 8'd0)
		else $error("read byte set on a non-read result");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.mode == MODE_READ |=> busy)
		else $error("read request did not hold busy");

	a_grant_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> !result_valid ##1 result_valid)
		else $error("grant sequence broken");

endmodule

bind bitmap_first_fit_block_allocator bffa_checker u_bffa_checker (.*);

// ----- bench/bitmap_first_fit_block_allocator_tb.sv -----
module bitmap_first_fit_block_allocator_tb;
	import bffa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BITS_PER_BYTE  = 8;
	localparam int MAP_BITS       = MAP_BYTES_DEF * BITS_PER_BYTE;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 40;
	localparam int REQ_W          = $bits(req_t);

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_REGION_BLOCKS;
	logic [31:0] cfg_data = '0;
	logic        result_valid;
	res_t        result;

	logic [7:0]  used_shadow [MAP_BYTES_DEF];
	logic [15:0] blocks_cfg = REGION_BLOCKS_RST;
	logic [31:0] offset_cfg = '0;
	res_t        pending_results [$];
	res_t        want;
	bit          idle_gaps = 1'b1;
	int          fails = 0;
	int          quiet_cycles = 0;

	bitmap_first_fit_block_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic req_t make_req(input logic [1:0] mode, input logic [11:0] idx,
			input logic [7:0] val, input logic [3:0] cnt);
		req_t r;
		r.mode          = mode;
		r.byte_index    = idx;
		r.byte_value    = val;
		r.request_count = cnt;
		return r;
	endfunction

	task automatic apply_request(input req_t r);
		int   hits [$];
		int   scan_end;
		res_t x;
		x = '0;
		x.last = 1'b1;
		case (r.mode)
			MODE_LOAD: begin
				used_shadow[r.byte_index] = r.byte_value;
			end
			MODE_READ: begin
				x.read_byte = used_shadow[r.byte_index];
				x.status = RES_READ;
				pending_results.push_back(x);
			end
			MODE_ALLOC: begin
				if (r.request_count == 0) begin
					x.status = RES_EMPTY;
					pending_results.push_back(x);
				end else if (r.request_count > MAX_RUN_DEF) begin
					x.status = RES_TOO_LARGE;
					pending_results.push_back(x);
				end else begin
					scan_end = (blocks_cfg < MAP_BITS) ? int'(blocks_cfg) : MAP_BITS;
					for (int i = 0; i < scan_end && hits.size() < r.request_count; i++)
						if (!used_shadow[i / BITS_PER_BYTE][i % BITS_PER_BYTE])
							hits.push_back(i);
					if (hits.size() < r.request_count) begin
						x.status = RES_NO_SPACE;
						pending_results.push_back(x);
					end else begin
						foreach (hits[k]) begin
							used_shadow[hits[k] / BITS_PER_BYTE][hits[k] % BITS_PER_BYTE] = 1'b1;
							x.block_number = offset_cfg + 32'(hits[k]);
							x.status = RES_GRANTED;
							x.last = (k == hits.size() - 1);
							pending_results.push_back(x);
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_request(input req_t r);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		apply_request(r);
		if (idle_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic wait_drained;
		start <= 1'b0;
		do @(posedge clk); while (busy || pending_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [15:0] blocks, input logic [31:0] offset);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_REGION_BLOCKS;
		cfg_data <= {16'h0000, blocks};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= CFG_REGION_OFFSET;
		cfg_data <= offset;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		blocks_cfg = blocks;
		offset_cfg = offset;
	endtask

	task automatic test_reset_state;
		send_request(make_req(MODE_READ, 12'd0, 8'h00, 4'd0));
		send_request(make_req(MODE_READ, 12'd4095, 8'hFF, 4'd15));
		send_request(make_req(MODE_ALLOC, 12'd0, 8'h00, 4'd0));
		send_request(make_req(MODE_ALLOC, 12'd0, 8'h00, 4'd13));
		send_request(make_req(MODE_ALLOC, 12'hFFF, 8'hFF, 4'd15));
		send_request(make_req(MODE_ALLOC, 12'd0, 8'h00, 4'd12));
		send_request(make_req(MODE_ALLOC, 12'd0, 8'h00, 4'd1));
		send_request(make_req(MODE_UNUSED, 12'd0, 8'hFF, 4'd1));
		send_request(make_req(MODE_READ, 12'd0, 8'h00, 4'd0));
		send_request(make_req(MODE_READ, 12'd1, 8'h00, 4'd0));
		send_request(make_req(MODE_LOAD, 12'd1, 8'h00, 4'd0));
		send_request(make_req(MODE_READ, 12'd1, 8'h00, 4'd0));
	endtask

	task automatic test_offset_wrap;
		wait_drained();
		configure(16'd20, 32'hFFFF_FFFC);
		send_request(make_req(MODE_ALLOC, 12'd0, 8'h00, 4'd12));
		send_request(make_req(MODE_ALLOC, 12'd0, 8'h00, 4'd1));
		send_request(make_req(MODE_LOAD, 12'd0, 8'hA5, 4'd0));
		send_request(make_req(MODE_ALLOC, 12'd0, 8'h00, 4'd4));
		send_request(make_req(MODE_READ, 12'd0, 8'h00, 4'd0));
	endtask

	task automatic test_empty_region;
		wait_drained();
		configure(16'd0, 32'h1234_5678);
		send_request(make_req(MODE_ALLOC, 12'd0, 8'h00, 4'd1));
		send_request(make_req(MODE_ALLOC, 12'd0, 8'h00, 4'd0));
		send_request(make_req(MODE_ALLOC, 12'd0, 8'h00, 4'd15));
	endtask

	task automatic test_region_beyond_map;
		wait_drained();
		configure(16'hFFFF, 32'h0000_1000);
		send_request(make_req(MODE_LOAD, 12'd4095, 8'h7F, 4'd0));
		send_request(make_req(MODE_READ, 12'd4095, 8'h00, 4'd0));
		send_request(make_req(MODE_ALLOC, 12'd0, 8'h00, 4'd2));
		send_request(make_req(MODE_ALLOC, 12'd0, 8'h00, 4'd1));
		wait_drained();
		configure(REGION_BLOCKS_RST, 32'h0000_0000);
		send_request(make_req(MODE_ALLOC, 12'd0, 8'h00, 4'd1));
		send_request(make_req(MODE_READ, 12'd4095, 8'h00, 4'd0));
	endtask

	task automatic test_random_traffic;
		logic [15:0] spans [8] = '{16'd64, 16'd8, 16'd96, 16'd1, 16'd200, 16'hFFFF, 16'd16,
			16'd48};
		req_t r;
		int   roll;
		int   span_bytes;
		for (int p = 0; p < 8; p++) begin
			wait_drained();
			configure(spans[p], (p == 0) ? 32'h0 : (p == 1) ? 32'hFFFF_FFFF :
				(p == 4) ? 32'h8000_0000 : $urandom);
			idle_gaps = (p != 7);
			span_bytes = (int'(blocks_cfg) + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
			if (span_bytes < 1)
				span_bytes = 1;
			if (span_bytes > MAP_BYTES_DEF)
				span_bytes = MAP_BYTES_DEF;
			for (int n = 0; n < 36; n++) begin
				r = REQ_W'($urandom);
				roll = $urandom_range(0, 99);
				if (roll < 35) begin
					r.mode = MODE_LOAD;
					r.byte_index = 12'($urandom_range(0, span_bytes - 1));
				end else if (roll < 75) begin
					r.mode = MODE_ALLOC;
					r.request_count = 4'($urandom_range(1, MAX_RUN_DEF));
				end else if (roll < 88) begin
					r.mode = MODE_READ;
					r.byte_index = 12'($urandom_range(0, span_bytes - 1));
				end
				send_request(r);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: got %p", $time, result);
				fails++;
			end else begin
				want = pending_results.pop_front();
				if (result.block_number !== want.block_number) begin
					$display("%0t: block_number expected %h got %h", $time,
						want.block_number, result.block_number);
					fails++;
				end
				if (result.read_byte !== want.read_byte) begin
					$display("%0t: read_byte expected %h got %h", $time,
						want.read_byte, result.read_byte);
					fails++;
				end
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						want.status, result.status);
					fails++;
				end
				if (result.last !== want.last) begin
					$display("%0t: last expected %b got %b", $time, want.last, result.last);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		foreach (used_shadow[i])
			used_shadow[i] = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_offset_wrap();
		test_empty_region();
		test_region_beyond_map();
		test_random_traffic();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
